>>> src/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants of the stream matcher
// Command codes, field widths, default sizes and the control word that the
// top level broadcasts to every cell of the matching row.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // default sizes
    localparam int PATTERN_MAX_DEF   = 256;
    localparam int POSITION_BITS_DEF = 16;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int SYMBOL_W = 8;
    localparam int START_W  = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    // per-transfer control broadcast to the cell row
    typedef struct packed {
        logic append;   // shift a new pattern byte in at cell 0
        logic text;     // step the prefix trackers by one text byte
        logic clear;    // drop pattern and all trackers
        logic restart;  // drop trackers, keep pattern
    } kmp_ctrl_t;

endpackage

>>> src/kmp_cell.sv
// ----------------------------------------------------------------------------
// kmp_cell: one slot of the matching row
// Holds one pattern byte, a loaded flag and a prefix tracker bit. The pattern
// is kept newest byte first, so cell 0 holds the last pattern byte and the
// hit of cell 0 marks a full occurrence. Trackers move towards cell 0 on
// text bytes; bytes, flags and trackers move away from it on pattern appends.
// ----------------------------------------------------------------------------
module kmp_cell
    import kmp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  kmp_ctrl_t           ctrl,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic                head,          // set on cell 0 only
    // from the neighbour nearer cell 0 (append shift)
    input  logic [SYMBOL_W-1:0] shift_byte,
    input  logic                shift_loaded,
    input  logic                shift_track,
    // from the neighbour further from cell 0 (text step)
    input  logic                up_loaded,
    input  logic                up_track,
    // to the neighbours
    output logic [SYMBOL_W-1:0] pat_byte,
    output logic                loaded,
    output logic                track,
    output logic                hit
);

    logic [SYMBOL_W-1:0] pat_byte_reg;
    logic [SYMBOL_W-1:0] pat_byte_next;
    logic                loaded_reg;
    logic                loaded_next;
    logic                track_reg;
    logic                track_next;

    // prefix through this byte matches: the oldest loaded cell starts a prefix
    assign hit = loaded_reg && (pat_byte_reg == symbol) && (up_loaded ? up_track : 1'b1);

    // next state
    always_comb
    begin
        pat_byte_next = pat_byte_reg;
        loaded_next   = loaded_reg;
        track_next    = track_reg;
        if (ctrl.clear)
        begin
            loaded_next = 1'b0;
            track_next  = 1'b0;
        end
        else if (ctrl.restart)
        begin
            track_next = 1'b0;
        end
        else if (ctrl.append)
        begin
            pat_byte_next = shift_byte;
            loaded_next   = shift_loaded;
            track_next    = shift_track;
        end
        else if (ctrl.text)
        begin
            // a full occurrence falls back to its border, so cell 0 keeps nothing
            track_next = hit && !head;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            track_reg  <= 1'b0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            track_reg  <= track_next;
        end
    end

    // pattern byte, meaningful only while loaded
    always_ff @(posedge clk)
    begin
        pat_byte_reg <= pat_byte_next;
    end

    assign pat_byte = pat_byte_reg;
    assign loaded   = loaded_reg;
    assign track    = track_reg;

endmodule

>>> src/kmp_stream_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core: streaming prefix-automaton string matcher
// Pattern bytes are appended, text bytes are streamed, and each text byte
// reports whether it completes an occurrence and where that occurrence starts.
// Overlapping occurrences are found; an empty pattern never matches.
//
//   channel   dir  payload                              one transfer
//   s_axis    in   tuser: command, tdata: symbol        one command item
//   m_axis    out  tuser: match_found, tdata: start     one result item
//
// The whole cell row updates at the accepting edge and the result sits in
// the output register from the next cycle.
// The input is taken whenever the output register is empty or being drained,
// so a stalled output holds one result and stops the input.
// Reset clears the pattern, the trackers and the text position at once.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] match_start
    output logic [0:0]  m_tuser    // [0] match_found
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int SUM_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;

    logic                     accept;
    kmp_ctrl_t                ctrl;
    logic                     full;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [SUM_W-1:0]         start_wide;
    logic [POSITION_BITS-1:0] start_pos;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic                     found_next;
    logic [START_W-1:0]       start_reg;
    logic [START_W-1:0]       start_next;

    logic [SYMBOL_W-1:0]      byte_chain   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   loaded_chain;
    logic [PATTERN_MAX-1:0]   track_chain;
    logic [PATTERN_MAX-1:0]   hit_chain;

    // handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (len_reg == LEN_W'(PATTERN_MAX));

    // command decode into the row control word
    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            case (s_tuser)
                CMD_APPEND:  ctrl.append  = !full;
                CMD_TEXT:    ctrl.text    = 1'b1;
                CMD_CLEAR:   ctrl.clear   = 1'b1;
                CMD_RESTART: ctrl.restart = 1'b1;
                default:     ctrl         = '0;
            endcase
        end
    end

    // row of cells, cell 0 holds the newest pattern byte
    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [SYMBOL_W-1:0] sh_byte;
        logic                sh_loaded;
        logic                sh_track;
        logic                up_loaded;
        logic                up_track;

        if (j == 0)
        begin : g_first
            assign sh_byte   = s_tdata;
            assign sh_loaded = 1'b1;
            assign sh_track  = 1'b0;
        end
        else
        begin : g_inner
            assign sh_byte   = byte_chain[j-1];
            assign sh_loaded = loaded_chain[j-1];
            assign sh_track  = track_chain[j-1];
        end

        if (j == PATTERN_MAX - 1)
        begin : g_last
            assign up_loaded = 1'b0;
            assign up_track  = 1'b0;
        end
        else
        begin : g_mid
            assign up_loaded = loaded_chain[j+1];
            assign up_track  = track_chain[j+1];
        end

        kmp_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .symbol       (s_tdata),
            .head         ((j == 0) ? 1'b1 : 1'b0),
            .shift_byte   (sh_byte),
            .shift_loaded (sh_loaded),
            .shift_track  (sh_track),
            .up_loaded    (up_loaded),
            .up_track     (up_track),
            .pat_byte     (byte_chain[j]),
            .loaded       (loaded_chain[j]),
            .track        (track_chain[j]),
            .hit          (hit_chain[j])
        );
    end

    // pattern length and text position
    assign pos_inc = pos_reg + POSITION_BITS'(1);

    always_comb
    begin
        len_next = len_reg;
        pos_next = pos_reg;
        if (ctrl.clear)
        begin
            len_next = '0;
            pos_next = '0;
        end
        else if (ctrl.restart)
        begin
            pos_next = '0;
        end
        else if (ctrl.append)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (ctrl.text)
        begin
            pos_next = pos_inc;
        end
    end

    // start of the occurrence ending at this byte, modulo the position range
    assign start_wide = SUM_W'(pos_inc) - SUM_W'(len_reg) + SUM_W'(1);
    assign start_pos  = start_wide[POSITION_BITS-1:0];

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            found_next     = ctrl.text && hit_chain[0];
            start_next     = (ctrl.text && hit_chain[0]) ? START_W'(start_pos) : '0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = start_reg;
    assign m_tuser[0] = found_reg;

endmodule
